### rtl/ocls_pkg.sv
package ocls_pkg;

    // Default channel count
    localparam int CHANNELS_DEF = 8;

    // Duty is given in per-mille and saturates at full scale
    localparam logic [15:0] DUTY_FULL = 16'd1000;
    localparam int DUTY_W = 10;

    // The product period*duty fits in 26 bits (65535 * 1000)
    localparam int PROD_W = 26;

    // Division by 1000 is done as a shift by 3 and a reciprocal multiply for 125.
    // The multiply gives the exact quotient for every dividend below 2^23.
    localparam int PRE_SHIFT = 3;
    localparam int DIVIDEND_W = PROD_W - PRE_SHIFT;
    localparam int RECIP_W = 24;
    localparam logic [RECIP_W-1:0] RECIP_125 = 24'd8589935;
    localparam int RECIP_SHIFT = 30;

    // Register defaults after reset
    localparam logic [15:0] MODES_RST = 16'd0;
    localparam logic [15:0] OVL_LIMIT_RST = 16'hFFFF;
    localparam logic [15:0] NLD_LIMIT_RST = 16'd0;
    localparam logic [15:0] OVL_TICKS_RST = 16'd100;
    localparam logic [15:0] NLD_TICKS_RST = 16'd100;
    localparam logic [15:0] PERIOD_RST = 16'd100;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        CFG_MODES     = 3'd0,
        CFG_OVL_LIMIT = 3'd1,
        CFG_NLD_LIMIT = 3'd2,
        CFG_OVL_TICKS = 3'd3,
        CFG_NLD_TICKS = 3'd4,
        CFG_PERIOD    = 3'd5
    } t_cfg_idx;

    // Channel operating modes; the unused code behaves as disabled
    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_SWITCH = 2'd1,
        MODE_PWM    = 2'd2
    } t_mode;

    // Load status codes
    typedef enum logic [1:0] {
        ST_OFF         = 2'd0,
        ST_ON          = 2'd1,
        ST_NOLOAD      = 2'd2,
        ST_OVERCURRENT = 2'd3
    } t_status;

    typedef struct packed {
        logic [15:0] channel_modes;
        logic [15:0] overload_limit;
        logic [15:0] noload_limit;
        logic [15:0] overload_ticks;
        logic [15:0] noload_ticks;
        logic [15:0] pwm_period;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  channel;
        logic [15:0] load_current;
        logic        switch_request;
        logic [15:0] duty_request;
    } t_item;

    // Between the channel update and the compare scaling stage
    typedef struct packed {
        logic [2:0]        channel;
        logic              switched_on;
        t_status           load_status;
        logic [PROD_W-1:0] product;
    } t_mid;

    typedef struct packed {
        logic [2:0]  channel_out;
        logic        switched_on;
        t_status     load_status;
        logic [15:0] compare_value;
    } t_result;

endpackage

### rtl/ocls_in_if.sv
interface ocls_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  channel;
    logic [15:0] load_current;
    logic        switch_request;
    logic [15:0] duty_request;

    modport source (
        output valid, channel, load_current, switch_request, duty_request,
        input  ready
    );
    modport sink (
        input  valid, channel, load_current, switch_request, duty_request,
        output ready
    );
endinterface

### rtl/ocls_out_if.sv
interface ocls_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  channel_out;
    logic        switched_on;
    logic [1:0]  load_status;
    logic [15:0] compare_value;

    modport source (
        output valid, channel_out, switched_on, load_status, compare_value,
        input  ready
    );
    modport sink (
        input  valid, channel_out, switched_on, load_status, compare_value,
        output ready
    );
endinterface

### rtl/ocls_core.sv
module ocls_core #(
    parameter int CHANNELS = ocls_pkg::CHANNELS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ocls_pkg::t_cfg   i_cfg,
    input  ocls_pkg::t_item  i_item,
    input  logic             i_update,
    output ocls_pkg::t_mid   o_mid
);

    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Per-channel state, one entry per channel
    logic              r_sw [CHANNELS];
    ocls_pkg::t_status r_st [CHANNELS];
    logic [15:0]       r_oc [CHANNELS];
    logic [15:0]       r_nc [CHANNELS];

    logic                          in_range;
    logic [IW-1:0]                 idx;
    ocls_pkg::t_mode               mode;
    logic                          sw0;
    ocls_pkg::t_status             st0;
    logic [15:0]                   oc0;
    logic [15:0]                   nc0;
    logic                          n_sw;
    ocls_pkg::t_status             n_st;
    logic [15:0]                   n_oc;
    logic [15:0]                   n_nc;
    logic [16:0]                   up_oc;
    logic [16:0]                   up_nc;
    logic [ocls_pkg::DUTY_W-1:0]   duty_sat;
    logic [ocls_pkg::DUTY_W-1:0]   duty_eff;

    // Saturating increment; the top bit flags that the ceiling was passed
    function automatic logic [16:0] count_up(input logic [15:0] cnt,
                                             input logic [15:0] ceiling);
        logic [15:0] v;
        v = (cnt == 16'hFFFF) ? cnt : cnt + 16'd1;
        if (v > ceiling) begin
            return {1'b1, ceiling};
        end
        return {1'b0, v};
    endfunction

    assign in_range = int'(i_item.channel) < CHANNELS;
    assign idx      = i_item.channel[IW-1:0];
    assign mode     = ocls_pkg::t_mode'(i_cfg.channel_modes[{i_item.channel, 1'b0} +: 2]);

    assign sw0 = r_sw[idx];
    assign st0 = r_st[idx];
    assign oc0 = r_oc[idx];
    assign nc0 = r_nc[idx];

    assign up_oc = count_up(oc0, i_cfg.overload_ticks);
    assign up_nc = count_up(nc0, i_cfg.noload_ticks);

    assign duty_sat = (i_item.duty_request > ocls_pkg::DUTY_FULL)
                    ? ocls_pkg::DUTY_FULL[ocls_pkg::DUTY_W-1:0]
                    : i_item.duty_request[ocls_pkg::DUTY_W-1:0];

    // Channel update for the current beat
    always_comb begin
        n_sw     = sw0;
        n_st     = st0;
        n_oc     = oc0;
        n_nc     = nc0;
        duty_eff = '0;
        case (mode)
            ocls_pkg::MODE_SWITCH: begin
                if (st0 != ocls_pkg::ST_OVERCURRENT) begin
                    n_sw = i_item.switch_request;
                    if (st0 != ocls_pkg::ST_NOLOAD) begin
                        n_st = i_item.switch_request ? ocls_pkg::ST_ON : ocls_pkg::ST_OFF;
                    end
                end else begin
                    n_sw = 1'b0;
                end
                if (n_sw) begin
                    if (i_item.load_current > i_cfg.overload_limit) begin
                        n_oc = up_oc[15:0];
                        if (up_oc[16]) begin
                            n_st = ocls_pkg::ST_OVERCURRENT;
                        end
                    end else if (i_item.load_current < i_cfg.noload_limit) begin
                        n_nc = up_nc[15:0];
                        if (up_nc[16]) begin
                            n_st = ocls_pkg::ST_NOLOAD;
                        end
                    end else begin
                        if (oc0 != 16'd0) begin
                            n_oc = oc0 - 16'd1;
                        end
                        if (nc0 != 16'd0) begin
                            n_nc = nc0 - 16'd1;
                        end else if (n_st == ocls_pkg::ST_NOLOAD) begin
                            n_st = ocls_pkg::ST_ON;
                        end
                    end
                end
                duty_eff = n_sw ? ocls_pkg::DUTY_FULL[ocls_pkg::DUTY_W-1:0] : '0;
            end
            ocls_pkg::MODE_PWM: begin
                if (i_item.load_current > i_cfg.overload_limit) begin
                    n_oc = up_oc[15:0];
                    if (up_oc[16]) begin
                        n_st = ocls_pkg::ST_OVERCURRENT;
                    end
                end else if (oc0 != 16'd0) begin
                    n_oc = oc0 - 16'd1;
                end
                duty_eff = (n_st != ocls_pkg::ST_OVERCURRENT) ? duty_sat : '0;
            end
            default: begin
                n_sw = 1'b0;
                n_st = ocls_pkg::ST_OFF;
            end
        endcase
    end

    // State write-back as the beat moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_sw[c] <= 1'b0;
                r_st[c] <= ocls_pkg::ST_OFF;
                r_oc[c] <= '0;
                r_nc[c] <= '0;
            end
        end else if (i_update && in_range) begin
            r_sw[idx] <= n_sw;
            r_st[idx] <= n_st;
            r_oc[idx] <= n_oc;
            r_nc[idx] <= n_nc;
        end
    end

    // Result of the update; a channel out of range reports switched off, status off and a zero product
    always_comb begin
        o_mid.channel     = i_item.channel;
        o_mid.switched_on = in_range ? n_sw : 1'b0;
        o_mid.load_status = in_range ? n_st : ocls_pkg::ST_OFF;
        o_mid.product     = in_range
                          ? ocls_pkg::PROD_W'(i_cfg.pwm_period) * ocls_pkg::PROD_W'(duty_eff)
                          : '0;
    end

endmodule

### rtl/ocls_scale.sv
module ocls_scale (
    input  ocls_pkg::t_mid    i_mid,
    output ocls_pkg::t_result o_res
);

    localparam int FULL_W = ocls_pkg::DIVIDEND_W + ocls_pkg::RECIP_W;

    logic [ocls_pkg::DIVIDEND_W-1:0] dividend;
    logic [FULL_W-1:0]               full;
    logic [15:0]                     quot;

    // Divide by 1000: drop three bits, then multiply by the reciprocal of 125
    assign dividend = i_mid.product[ocls_pkg::PROD_W-1:ocls_pkg::PRE_SHIFT];
    assign full     = FULL_W'(dividend) * FULL_W'(ocls_pkg::RECIP_125);
    assign quot     = full[ocls_pkg::RECIP_SHIFT +: 16];

    // A zero quotient gives a zero compare value instead of wrapping
    always_comb begin
        o_res.channel_out   = i_mid.channel;
        o_res.switched_on   = i_mid.switched_on;
        o_res.load_status   = i_mid.load_status;
        o_res.compare_value = (quot == 16'd0) ? 16'd0 : quot - 16'd1;
    end

endmodule

### rtl/output_channel_load_supervisor.sv
// Load supervisor for up to eight switched or PWM outputs. Each input beat is one
// millisecond tick for one channel; it updates that channel's switch state, load
// status and fault counters and returns one result beat with the new state and the
// PWM compare value period*duty/1000-1. The block takes one beat per clock cycle
// while the output is not stalled. A beat passes three registers (input, channel
// update, compare scaling) before its result is presented; the split into stages is
// set by the two multiplies of the compare scaling. Ticks for the same channel may
// follow each other back to back. The user must write registers on the configuration
// port only while no beat is in flight; the block itself does not enforce this.
module output_channel_load_supervisor #(
    parameter int CHANNELS = ocls_pkg::CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ocls_in_if.sink     i_item,
    ocls_out_if.source  o_result,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    ocls_pkg::t_cfg    r_cfg;
    ocls_pkg::t_item   r_in;
    ocls_pkg::t_mid    r_mid;
    ocls_pkg::t_result r_out;
    logic              r_v1;
    logic              r_v2;
    logic              r_vo;

    ocls_pkg::t_mid    mid;
    ocls_pkg::t_result res;
    logic              rdy_o;
    logic              rdy2;
    logic              rdy1;
    logic              adv1;
    logic              adv2;

    // Stage handshakes: each stage loads when empty or when its beat moves on
    assign rdy_o = !r_vo || o_result.ready;
    assign rdy2  = !r_v2 || rdy_o;
    assign rdy1  = !r_v1 || rdy2;
    assign adv1  = r_v1 && rdy2;
    assign adv2  = r_v2 && rdy_o;

    assign i_item.ready = rdy1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_modes  <= ocls_pkg::MODES_RST;
            r_cfg.overload_limit <= ocls_pkg::OVL_LIMIT_RST;
            r_cfg.noload_limit   <= ocls_pkg::NLD_LIMIT_RST;
            r_cfg.overload_ticks <= ocls_pkg::OVL_TICKS_RST;
            r_cfg.noload_ticks   <= ocls_pkg::NLD_TICKS_RST;
            r_cfg.pwm_period     <= ocls_pkg::PERIOD_RST;
        end else if (i_cfg_we) begin
            case (ocls_pkg::t_cfg_idx'(i_cfg_idx))
                ocls_pkg::CFG_MODES:     r_cfg.channel_modes  <= i_cfg_data;
                ocls_pkg::CFG_OVL_LIMIT: r_cfg.overload_limit <= i_cfg_data;
                ocls_pkg::CFG_NLD_LIMIT: r_cfg.noload_limit   <= i_cfg_data;
                ocls_pkg::CFG_OVL_TICKS: r_cfg.overload_ticks <= i_cfg_data;
                ocls_pkg::CFG_NLD_TICKS: r_cfg.noload_ticks   <= i_cfg_data;
                ocls_pkg::CFG_PERIOD:    r_cfg.pwm_period     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_item.valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy_o) begin
                r_vo <= r_v2;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_item.valid) begin
            r_in.channel        <= i_item.channel;
            r_in.load_current   <= i_item.load_current;
            r_in.switch_request <= i_item.switch_request;
            r_in.duty_request   <= i_item.duty_request;
        end
        if (adv1) begin
            r_mid <= mid;
        end
        if (adv2) begin
            r_out <= res;
        end
    end

    ocls_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_item   (r_in),
        .i_update (adv1),
        .o_mid    (mid)
    );

    ocls_scale u_scale (
        .i_mid (r_mid),
        .o_res (res)
    );

    assign o_result.valid         = r_vo;
    assign o_result.channel_out   = r_out.channel_out;
    assign o_result.switched_on   = r_out.switched_on;
    assign o_result.load_status   = r_out.load_status;
    assign o_result.compare_value = r_out.compare_value;

    // An accepted beat always lands in the input stage
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> r_v1)
        else $error("accepted beat did not reach the input stage");

    // A full pipeline behind a stalled output takes no new beat
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_vo && !o_result.ready) |-> !i_item.ready)
        else $error("beat accepted into a full pipeline");

    // The compare value stays below the period unless it is zero
    a_cmp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo |-> (r_out.compare_value < r_cfg.pwm_period || r_out.compare_value == 16'd0))
        else $error("compare value at or above the period");

    // A channel out of range reports nothing but its number
    a_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && int'(r_out.channel_out) >= CHANNELS) |->
        (!r_out.switched_on && r_out.load_status == ocls_pkg::ST_OFF
         && r_out.compare_value == 16'd0))
        else $error("out-of-range channel reported state");

endmodule

### test/output_channel_load_supervisor_tb.sv
`timescale 1ns / 100ps

module output_channel_load_supervisor_tb;

    localparam int NUM_CH = 8;
    // Mode code that the block treats as disabled, and register indexes past the list.
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [2:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_IDX_SPARE_HI = 3'd7;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [15:0] i_cfg_data;

    ocls_in_if tick_if ();
    ocls_out_if status_if ();

    output_channel_load_supervisor u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (tick_if),
        .o_result   (status_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the registers and of the per-channel supervision state.
    ocls_pkg::t_cfg shadow_cfg;
    logic sw_on [NUM_CH];
    ocls_pkg::t_status ch_status [NUM_CH];
    logic [15:0] ovl_count [NUM_CH];
    logic [15:0] nld_count [NUM_CH];

    ocls_pkg::t_result pending_status[$];
    int mismatch_count = 0;
    bit send_gaps_on = 1'b1;
    bit recv_stalls_on = 1'b1;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // Saturating count up; returns 1 when the count would pass the ceiling.
    function automatic bit bump_counter(inout logic [15:0] cnt, input logic [15:0] ceiling);
        logic [16:0] next_cnt;
        next_cnt = {1'b0, cnt};
        if (cnt != 16'hFFFF) begin
            next_cnt = next_cnt + 17'd1;
        end
        if (next_cnt > {1'b0, ceiling}) begin
            cnt = ceiling;
            return 1'b1;
        end
        cnt = next_cnt[15:0];
        return 1'b0;
    endfunction

    // Per-mille duty to compare value, with a product that rounds to zero giving zero.
    function automatic logic [15:0] duty_to_compare(input logic [15:0] duty);
        logic [31:0] sat_duty;
        logic [31:0] quotient;
        sat_duty = (duty > ocls_pkg::DUTY_FULL) ? 32'(ocls_pkg::DUTY_FULL) : 32'(duty);
        if (sat_duty == 0) begin
            return 16'd0;
        end
        quotient = (32'(shadow_cfg.pwm_period) * sat_duty) / 32'(ocls_pkg::DUTY_FULL);
        if (quotient == 0) begin
            return 16'd0;
        end
        return 16'(quotient - 32'd1);
    endfunction

    // Applies one tick to the shadow state and returns the status beat it should produce.
    function automatic ocls_pkg::t_result supervise_tick(input ocls_pkg::t_item it);
        ocls_pkg::t_result res;
        int ch;
        logic [1:0] mode;
        ch = int'(it.channel);
        mode = shadow_cfg.channel_modes[2*ch +: 2];
        res.channel_out = it.channel;
        res.compare_value = 16'd0;
        if (mode == ocls_pkg::MODE_SWITCH) begin
            if (ch_status[ch] != ocls_pkg::ST_OVERCURRENT) begin
                sw_on[ch] = it.switch_request;
                if (ch_status[ch] != ocls_pkg::ST_NOLOAD) begin
                    ch_status[ch] = it.switch_request ? ocls_pkg::ST_ON : ocls_pkg::ST_OFF;
                end
            end else begin
                sw_on[ch] = 1'b0;
            end
            // Fault counting only while the output is switched on.
            if (sw_on[ch]) begin
                if (it.load_current > shadow_cfg.overload_limit) begin
                    if (bump_counter(ovl_count[ch], shadow_cfg.overload_ticks)) begin
                        ch_status[ch] = ocls_pkg::ST_OVERCURRENT;
                    end
                end else if (it.load_current < shadow_cfg.noload_limit) begin
                    if (bump_counter(nld_count[ch], shadow_cfg.noload_ticks)) begin
                        ch_status[ch] = ocls_pkg::ST_NOLOAD;
                    end
                end else begin
                    if (ovl_count[ch] != 0) begin
                        ovl_count[ch] = ovl_count[ch] - 16'd1;
                    end
                    if (nld_count[ch] != 0) begin
                        nld_count[ch] = nld_count[ch] - 16'd1;
                    end else if (ch_status[ch] == ocls_pkg::ST_NOLOAD) begin
                        ch_status[ch] = ocls_pkg::ST_ON;
                    end
                end
            end
            res.compare_value = duty_to_compare(sw_on[ch] ? ocls_pkg::DUTY_FULL : 16'd0);
        end else if (mode == ocls_pkg::MODE_PWM) begin
            if (it.load_current > shadow_cfg.overload_limit) begin
                if (bump_counter(ovl_count[ch], shadow_cfg.overload_ticks)) begin
                    ch_status[ch] = ocls_pkg::ST_OVERCURRENT;
                end
            end else if (ovl_count[ch] != 0) begin
                ovl_count[ch] = ovl_count[ch] - 16'd1;
            end
            if (ch_status[ch] != ocls_pkg::ST_OVERCURRENT) begin
                res.compare_value = duty_to_compare(it.duty_request);
            end
        end else begin
            sw_on[ch] = 1'b0;
            ch_status[ch] = ocls_pkg::ST_OFF;
        end
        res.switched_on = sw_on[ch];
        res.load_status = ch_status[ch];
        return res;
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Register write; the shadow copy follows once the write has been clocked in.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            ocls_pkg::CFG_MODES:     shadow_cfg.channel_modes = data;
            ocls_pkg::CFG_OVL_LIMIT: shadow_cfg.overload_limit = data;
            ocls_pkg::CFG_NLD_LIMIT: shadow_cfg.noload_limit = data;
            ocls_pkg::CFG_OVL_TICKS: shadow_cfg.overload_ticks = data;
            ocls_pkg::CFG_NLD_TICKS: shadow_cfg.noload_ticks = data;
            ocls_pkg::CFG_PERIOD:    shadow_cfg.pwm_period = data;
            default: ;
        endcase
    endtask

    // Sends one tick beat, after a random gap if gaps are on, and records the status it should yield.
    task automatic send_tick(input logic [2:0] ch, input logic [15:0] cur,
                             input logic req, input logic [15:0] duty);
        ocls_pkg::t_item it;
        int gap;
        it.channel = ch;
        it.load_current = cur;
        it.switch_request = req;
        it.duty_request = duty;
        gap = send_gaps_on ? $urandom_range(0, 4) : 0;
        for (int k = 0; k < gap; k++) begin
            @(negedge i_clk);
            tick_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        tick_if.valid <= 1'b1;
        tick_if.channel <= ch;
        tick_if.load_current <= cur;
        tick_if.switch_request <= req;
        tick_if.duty_request <= duty;
        do @(posedge i_clk); while (tick_if.ready !== 1'b1);
        pending_status.push_back(supervise_tick(it));
    endtask

    // Stops sending and waits until every status beat has come back.
    task automatic wait_idle();
        @(negedge i_clk);
        tick_if.valid <= 1'b0;
        while (pending_status.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Status beat receiver with random back-pressure.
    initial begin
        int stall;
        ocls_pkg::t_result want;
        status_if.ready = 1'b0;
        forever begin
            stall = recv_stalls_on ? $urandom_range(0, 4) : 0;
            for (int k = 0; k < stall; k++) begin
                @(negedge i_clk);
                status_if.ready <= 1'b0;
            end
            @(negedge i_clk);
            status_if.ready <= 1'b1;
            do @(posedge i_clk); while (status_if.valid !== 1'b1);
            if (pending_status.size() == 0) begin
                report_mismatch($sformatf("status beat for channel %0d with none pending",
                                          status_if.channel_out));
            end else begin
                want = pending_status.pop_front();
                if (status_if.channel_out !== want.channel_out) begin
                    report_mismatch($sformatf("channel_out %0d, expected %0d",
                                              status_if.channel_out, want.channel_out));
                end
                if (status_if.switched_on !== want.switched_on) begin
                    report_mismatch($sformatf("ch %0d switched_on %0b, expected %0b",
                                              want.channel_out, status_if.switched_on,
                                              want.switched_on));
                end
                if (status_if.load_status !== want.load_status) begin
                    report_mismatch($sformatf("ch %0d load_status %0d, expected %0d",
                                              want.channel_out, status_if.load_status,
                                              want.load_status));
                end
                if (status_if.compare_value !== want.compare_value) begin
                    report_mismatch($sformatf("ch %0d compare_value %0d, expected %0d",
                                              want.channel_out, status_if.compare_value,
                                              want.compare_value));
                end
            end
        end
    end

    // After reset every channel is disabled, so all fields but the channel read zero.
    task automatic test_disabled_default();
        send_tick(3'd0, 16'hFFFF, 1'b1, 16'hFFFF);
        send_tick(3'd7, 16'd0, 1'b0, 16'd0);
        wait_idle();
    endtask

    // On/off mode: following the request, no-load latch and recovery, overcurrent latch.
    task automatic test_switch_mode();
        write_reg(ocls_pkg::CFG_MODES, 16'h5555);
        write_reg(ocls_pkg::CFG_OVL_LIMIT, 16'd1000);
        write_reg(ocls_pkg::CFG_NLD_LIMIT, 16'd50);
        write_reg(ocls_pkg::CFG_OVL_TICKS, 16'd1);
        write_reg(ocls_pkg::CFG_NLD_TICKS, 16'd1);
        write_reg(ocls_pkg::CFG_PERIOD, 16'hFFFF);
        send_tick(3'd1, 16'd500, 1'b1, 16'd0);
        send_tick(3'd1, 16'd500, 1'b0, 16'd0);
        send_tick(3'd1, 16'd0, 1'b1, 16'd0);
        send_tick(3'd1, 16'd0, 1'b1, 16'd0);
        send_tick(3'd1, 16'd500, 1'b1, 16'd0);
        send_tick(3'd1, 16'd500, 1'b1, 16'd0);
        send_tick(3'd1, 16'hFFFF, 1'b1, 16'hFFFF);
        send_tick(3'd1, 16'hFFFF, 1'b1, 16'hFFFF);
        send_tick(3'd1, 16'd500, 1'b1, 16'd0);
        wait_idle();
    endtask

    // PWM mode: duty saturation, tiny products, zero duty and overcurrent forcing zero.
    task automatic test_pwm_mode();
        write_reg(ocls_pkg::CFG_MODES, 16'hAAAA);
        write_reg(ocls_pkg::CFG_OVL_TICKS, 16'd0);
        write_reg(ocls_pkg::CFG_PERIOD, 16'd1);
        send_tick(3'd2, 16'd0, 1'b0, 16'd1000);
        send_tick(3'd2, 16'd0, 1'b0, 16'd999);
        wait_idle();
        write_reg(ocls_pkg::CFG_PERIOD, 16'hFFFF);
        send_tick(3'd2, 16'd0, 1'b0, 16'hFFFF);
        send_tick(3'd2, 16'd0, 1'b1, 16'd0);
        send_tick(3'd2, 16'd0, 1'b0, 16'd1);
        send_tick(3'd2, 16'hFFFF, 1'b0, 16'd500);
        // Overcurrent latched in on/off mode stays latched in PWM mode.
        send_tick(3'd1, 16'd0, 1'b1, 16'd1000);
        wait_idle();
    endtask

    // Unused register indexes are ignored; the spare mode code clears the latch.
    task automatic test_spare_codes();
        write_reg(CFG_IDX_SPARE_LO, 16'h0000);
        write_reg(CFG_IDX_SPARE_HI, 16'hFFFF);
        send_tick(3'd2, 16'd0, 1'b1, 16'd1000);
        wait_idle();
        write_reg(ocls_pkg::CFG_MODES, {8{MODE_SPARE}});
        send_tick(3'd2, 16'd0, 1'b1, 16'd1000);
        wait_idle();
        write_reg(ocls_pkg::CFG_MODES, 16'hAAAA);
        send_tick(3'd2, 16'd0, 1'b1, 16'd1000);
        wait_idle();
    endtask

    // Random phases, each with its own register setting and a pair of busy channels.
    task automatic test_random();
        logic [15:0] modes;
        logic [15:0] nld_lim;
        logic [15:0] ovl_lim;
        logic [15:0] cur;
        logic [15:0] duty;
        logic [2:0] ch;
        logic [2:0] busy_a;
        logic [2:0] busy_b;
        int pick;
        for (int phase = 0; phase < 10; phase++) begin
            modes = '0;
            for (int c = 0; c < NUM_CH; c++) begin
                pick = $urandom_range(0, 9);
                modes[2*c +: 2] = (pick == 0) ? ocls_pkg::MODE_OFF :
                                  (pick == 1) ? MODE_SPARE :
                                  (pick < 6) ? ocls_pkg::MODE_SWITCH : ocls_pkg::MODE_PWM;
            end
            write_reg(ocls_pkg::CFG_MODES, modes);
            if (phase == 0) begin
                write_reg(ocls_pkg::CFG_OVL_LIMIT, 16'd0);
                write_reg(ocls_pkg::CFG_NLD_LIMIT, 16'hFFFF);
                write_reg(ocls_pkg::CFG_OVL_TICKS, 16'hFFFF);
                write_reg(ocls_pkg::CFG_NLD_TICKS, 16'hFFFF);
                write_reg(ocls_pkg::CFG_PERIOD, 16'hFFFF);
            end else if (phase == 1) begin
                write_reg(ocls_pkg::CFG_OVL_LIMIT, 16'hFFFF);
                write_reg(ocls_pkg::CFG_NLD_LIMIT, 16'd0);
                write_reg(ocls_pkg::CFG_OVL_TICKS, 16'd0);
                write_reg(ocls_pkg::CFG_NLD_TICKS, 16'd0);
                write_reg(ocls_pkg::CFG_PERIOD, 16'd1);
            end else begin
                nld_lim = 16'($urandom_range(0, 3000));
                ovl_lim = nld_lim + 16'($urandom_range(0, 3000));
                write_reg(ocls_pkg::CFG_OVL_LIMIT, ovl_lim);
                write_reg(ocls_pkg::CFG_NLD_LIMIT, nld_lim);
                write_reg(ocls_pkg::CFG_OVL_TICKS, ($urandom_range(0, 7) == 0) ?
                          16'($urandom) : 16'($urandom_range(0, 6)));
                write_reg(ocls_pkg::CFG_NLD_TICKS, ($urandom_range(0, 7) == 0) ?
                          16'($urandom) : 16'($urandom_range(0, 6)));
                pick = $urandom_range(0, 4);
                write_reg(ocls_pkg::CFG_PERIOD, (pick == 0) ? 16'($urandom_range(1, 50)) :
                                                (pick == 1) ? 16'd100 :
                                                (pick == 2) ? 16'hFFFF :
                                                16'($urandom_range(1000, 65535)));
            end
            send_gaps_on = ($urandom_range(0, 3) != 0);
            recv_stalls_on = ($urandom_range(0, 3) != 0);
            busy_a = 3'($urandom);
            busy_b = 3'($urandom);
            for (int n = 0; n < 125; n++) begin
                pick = $urandom_range(0, 9);
                ch = (pick < 4) ? busy_a : (pick < 7) ? busy_b : 3'($urandom);
                // Currents cluster around the thresholds so the counters move both ways.
                pick = $urandom_range(0, 7);
                if (pick < 2) begin
                    cur = (shadow_cfg.noload_limit == 0) ? 16'd0 :
                          16'($urandom_range(0, shadow_cfg.noload_limit - 1));
                end else if (pick < 4) begin
                    cur = (shadow_cfg.overload_limit == 16'hFFFF) ? 16'hFFFF :
                          16'($urandom_range(shadow_cfg.overload_limit + 1, 65535));
                end else if (pick < 7) begin
                    cur = 16'($urandom_range(shadow_cfg.noload_limit,
                                             shadow_cfg.overload_limit));
                end else begin
                    cur = 16'($urandom);
                end
                pick = $urandom_range(0, 4);
                duty = (pick == 0) ? 16'd0 :
                       (pick == 1) ? ocls_pkg::DUTY_FULL :
                       (pick == 2) ? 16'($urandom) : 16'($urandom_range(0, 1000));
                send_tick(ch, cur, ($urandom_range(0, 6) != 0), duty);
            end
            wait_idle();
        end
    endtask

    // Main sequence.
    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        tick_if.valid = 1'b0;
        tick_if.channel = '0;
        tick_if.load_current = '0;
        tick_if.switch_request = 1'b0;
        tick_if.duty_request = '0;
        shadow_cfg.channel_modes = ocls_pkg::MODES_RST;
        shadow_cfg.overload_limit = ocls_pkg::OVL_LIMIT_RST;
        shadow_cfg.noload_limit = ocls_pkg::NLD_LIMIT_RST;
        shadow_cfg.overload_ticks = ocls_pkg::OVL_TICKS_RST;
        shadow_cfg.noload_ticks = ocls_pkg::NLD_TICKS_RST;
        shadow_cfg.pwm_period = ocls_pkg::PERIOD_RST;
        for (int c = 0; c < NUM_CH; c++) begin
            sw_on[c] = 1'b0;
            ch_status[c] = ocls_pkg::ST_OFF;
            ovl_count[c] = '0;
            nld_count[c] = '0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_disabled_default();
        test_switch_mode();
        test_pwm_mode();
        test_spare_codes();
        test_random();

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### files.f
rtl/ocls_pkg.sv
rtl/ocls_in_if.sv
rtl/ocls_out_if.sv
rtl/ocls_core.sv
rtl/ocls_scale.sv
rtl/output_channel_load_supervisor.sv
test/output_channel_load_supervisor_tb.sv
